### rtl/bev_pkg.sv
// Shared types, constants and operation codes of the occupancy grid core.
package bev_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned GridCols  = 1024;
  localparam int unsigned GridRows  = 1024;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BUILD = 2'd1,
    OP_READ  = 2'd2,
    OP_FRAME = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_HLIMIT = 2'd1,
    REG_VOXEL  = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [9:0]         read_row;
    logic [3:0]         read_word;
  } cmd_t;

  typedef struct packed {
    logic [63:0]        cell_bits;
    logic [10:0]        grid_width;
    logic [10:0]        grid_height;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [12:0]        kept_count;
    logic               points_dropped;
    logic               map_clipped;
  } rsp_t;

  // Scaled point handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]         op;
    logic               keep;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [9:0]         read_row;
    logic [3:0]         read_word;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIMS,
    ST_WALK,
    ST_MARK,
    ST_READ,
    ST_DONE
  } back_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN
  } div_e;

endpackage

### rtl/bev_front.sv
// Front part: registers the scaled point, then classifies it against the height limit.
module bev_front import bev_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  cmd_t               cmd_i,
  input  logic [23:0]        scale_ratio_i,
  input  logic signed [31:0] height_limit_i,
  output logic               busy_o,
  output logic               job_valid_o,
  output job_t               job_o,
  input  logic               job_ready_i
);

  logic               stg_q, stg_d;
  cmd_t               cmd_q;
  logic signed [56:0] px_q, py_q, pz_q;
  logic               out_q, out_d;
  job_t               job_q;

  function automatic logic signed [31:0] sat_q(input logic signed [56:0] p);
    logic signed [40:0] q;
    begin
      q = 41'(p >>> 16);
      if (q > 41'sd2147483647) sat_q = 32'sh7FFFFFFF;
      else if (q < -41'sd2147483648) sat_q = 32'sh80000000;
      else sat_q = q[31:0];
    end
  endfunction

  logic signed [31:0] sx, sy, sz;
  assign sx = sat_q(px_q);
  assign sy = sat_q(py_q);
  assign sz = sat_q(pz_q);

  assign busy_o      = stg_q | (out_q & ~job_ready_i);
  assign job_valid_o = out_q;
  assign job_o       = job_q;
  assign stg_d       = in_valid_i & ~busy_o;
  assign out_d       = stg_q | (out_q & ~job_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= 1'b0;
      out_q <= 1'b0;
    end else begin
      stg_q <= stg_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_d) begin
      cmd_q <= cmd_i;
      px_q  <= 57'(cmd_i.coord_x) * $signed({33'd0, scale_ratio_i});
      py_q  <= 57'(cmd_i.coord_y) * $signed({33'd0, scale_ratio_i});
      pz_q  <= 57'(cmd_i.coord_z) * $signed({33'd0, scale_ratio_i});
    end
    if (stg_q) begin
      job_q.op        <= cmd_q.op;
      job_q.keep      <= sz > height_limit_i;
      job_q.x         <= sx;
      job_q.y         <= sy;
      job_q.read_row  <= cmd_q.read_row;
      job_q.read_word <= cmd_q.read_word;
    end
  end

endmodule

### rtl/bev_queue.sv
// Two-entry job queue between the front and back parts.
module bev_queue import bev_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic ready_o,
  output logic valid_o,
  output job_t pop_data_o,
  input  logic pop_i
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign ready_o    = cnt_q != 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule

### rtl/bev_div.sv
// Radix-2 restoring divider for a 33-bit dividend by a 31-bit divisor.
module bev_div import bev_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] num_i,
  input  logic [30:0] den_i,
  output logic        done_o,
  output logic [32:0] quo_o
);

  div_e        st_q, st_d;
  logic [5:0]  cnt_q;
  logic [32:0] quo_q;
  logic [31:0] rem_q;
  logic [30:0] den_q;
  logic [32:0] trial;

  assign trial  = {rem_q, quo_q[32]} - {2'b0, den_q};
  assign quo_o  = quo_q;
  assign done_o = (st_q == DV_RUN) && (cnt_q == 6'd0);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      DV_IDLE: if (start_i) st_d = DV_RUN;
      DV_RUN:  if (cnt_q == 6'd0) st_d = DV_IDLE;
      default: st_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= DV_IDLE;
      cnt_q <= 6'd0;
    end else begin
      st_q <= st_d;
      if (st_q == DV_IDLE && start_i) cnt_q <= 6'd33;
      else if (st_q == DV_RUN && cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == DV_IDLE && start_i) begin
      quo_q <= num_i;
      rem_q <= 32'd0;
      den_q <= (den_i == 31'd0) ? 31'd1 : den_i;
    end else if (st_q == DV_RUN && cnt_q != 6'd0) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[31:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[32]};
        quo_q <= {quo_q[31:0], 1'b0};
      end
    end
  end

endmodule

### rtl/bev_back.sv
// Back part: point store, bounding box, map build and grid word reads.
module bev_back import bev_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPoints,
  parameter int unsigned GRID_COLS  = GridCols,
  parameter int unsigned GRID_ROWS  = GridRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  input  logic [30:0] voxel_size_i,
  output logic        res_valid_o,
  output rsp_t        res_o
);

  localparam int unsigned WordsPerRow = (GRID_COLS + 63) / 64;
  localparam int unsigned GridWords   = GRID_ROWS * WordsPerRow;
  localparam int unsigned PtAw        = $clog2(MAX_POINTS);
  localparam int unsigned CntW        = $clog2(MAX_POINTS + 1);
  localparam int unsigned GwAw        = (GridWords > 1) ? $clog2(GridWords) : 1;
  localparam int unsigned WpW         = (WordsPerRow > 1) ? $clog2(WordsPerRow) : 1;

  logic [63:0] pt_mem [MAX_POINTS];
  logic [63:0] grid_mem [GridWords];

  back_e st_q, st_d;

  logic [CntW-1:0]    total_q;
  logic signed [31:0] lox_q, hix_q, loy_q, hiy_q;
  logic [10:0]        bw_q, bh_q;
  logic               drop_q, clip_q;
  logic [GwAw:0]      clr_q;
  logic [GwAw-1:0]    mark_q;
  logic [CntW-1:0]    idx_q;
  logic [1:0]         sub_q;
  logic [63:0]        pt_rd_q, grid_rd_q, cell_q;
  logic [32:0]        cx_q;
  logic               rd_ok_q;
  job_t               job_q;

  logic        dv_start, dv_done;
  logic [32:0] dv_num, dv_quo;

  bev_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_num),
    .den_i  (voxel_size_i),
    .done_o (dv_done),
    .quo_o  (dv_quo)
  );

  // sub_q steps: 0 start x, 1 wait x, 2 start y, 3 wait y
  always_comb begin
    dv_start = 1'b0;
    dv_num   = 33'd0;
    if ((st_q == ST_DIMS || st_q == ST_WALK) && !sub_q[0]) begin
      dv_start = 1'b1;
      if (st_q == ST_DIMS)
        dv_num = sub_q[1] ? 33'(34'(hiy_q) - 34'(loy_q)) : 33'(34'(hix_q) - 34'(lox_q));
      else
        dv_num = sub_q[1] ? 33'(34'($signed(pt_rd_q[63:32])) - 34'(loy_q))
                          : 33'(34'($signed(pt_rd_q[31:0])) - 34'(lox_q));
    end
  end

  logic        cur_add, cur_full;
  logic [10:0] rowsel;
  logic [GwAw-1:0] mark_addr, read_addr;

  assign cur_full = total_q >= CntW'(MAX_POINTS);

  always_comb begin
    st_d      = st_q;
    job_pop_o = 1'b0;
    cur_add   = 1'b0;
    unique case (st_q)
      ST_IDLE: if (job_valid_i) begin
        job_pop_o = 1'b1;
        unique case (job_i.op)
          OP_BUILD: st_d = ST_CLEAR;
          OP_READ:  st_d = ST_READ;
          default: begin
            cur_add = 1'b1;
            st_d    = ST_DONE;
          end
        endcase
      end
      ST_CLEAR: if (clr_q == (GwAw+1)'(GridWords - 1)) st_d = ST_DIMS;
      ST_DIMS:  if (dv_done && sub_q == 2'd3) st_d = (total_q == '0) ? ST_DONE : ST_WALK;
      ST_WALK:  if (dv_done && sub_q == 2'd3) st_d = ST_MARK;
      ST_MARK:  st_d = (idx_q == total_q) ? ST_DONE : ST_WALK;
      ST_READ:  st_d = ST_DONE;
      ST_DONE:  st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  logic [32:0] cy_fin;
  logic        in_map;
  assign cy_fin = dv_quo;
  assign in_map = (cx_q < 33'(bw_q)) && (cy_fin < 33'(bh_q));
  assign rowsel = bh_q - 11'd1 - cy_fin[10:0];
  assign mark_addr = GwAw'(rowsel * WordsPerRow + (cx_q[10:0] >> 6));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      total_q <= '0;
      lox_q   <= 32'sh7FFFFFFF;
      loy_q   <= 32'sh7FFFFFFF;
      hix_q   <= 32'sh80000000;
      hiy_q   <= 32'sh80000000;
      bw_q    <= 11'd0;
      bh_q    <= 11'd0;
      drop_q  <= 1'b0;
      clip_q  <= 1'b0;
      clr_q   <= '0;
      idx_q   <= '0;
      sub_q   <= 2'd0;
      res_valid_o <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_o <= (st_q == ST_DONE);
      if (cur_add) begin
        if (job_i.op == OP_FRAME) begin
          total_q <= '0;
          lox_q   <= 32'sh7FFFFFFF;
          loy_q   <= 32'sh7FFFFFFF;
          hix_q   <= 32'sh80000000;
          hiy_q   <= 32'sh80000000;
          drop_q  <= 1'b0;
        end else if (job_i.keep) begin
          if (cur_full) drop_q <= 1'b1;
          else begin
            total_q <= total_q + CntW'(1);
            if (job_i.x < lox_q) lox_q <= job_i.x;
            if (job_i.x > hix_q) hix_q <= job_i.x;
            if (job_i.y < loy_q) loy_q <= job_i.y;
            if (job_i.y > hiy_q) hiy_q <= job_i.y;
          end
        end
      end
      if (st_q == ST_IDLE) begin
        clr_q <= '0;
        idx_q <= '0;
        sub_q <= 2'd0;
      end
      if (st_q == ST_CLEAR) begin
        clr_q <= clr_q + (GwAw+1)'(1);
        clip_q <= 1'b0;
      end
      if (st_q == ST_DIMS || st_q == ST_WALK) begin
        if (!sub_q[0]) sub_q <= sub_q + 2'd1;
        else if (dv_done) begin
          sub_q <= sub_q + 2'd1;
          if (st_q == ST_DIMS) begin
            if (sub_q == 2'd1) begin
              if (total_q == '0) bw_q <= 11'd0;
              else if (dv_quo > 33'(GRID_COLS)) begin
                bw_q <= 11'(GRID_COLS); clip_q <= 1'b1;
              end else bw_q <= dv_quo[10:0];
            end else begin
              if (total_q == '0) bh_q <= 11'd0;
              else if (dv_quo > 33'(GRID_ROWS)) begin
                bh_q <= 11'(GRID_ROWS); clip_q <= 1'b1;
              end else bh_q <= dv_quo[10:0];
            end
          end else if (sub_q == 2'd3) begin
            idx_q <= idx_q + CntW'(1);
          end
        end
      end
    end
  end

  // Point store and grid memories; pt_rd_q prefetches the point being walked.
  logic [PtAw-1:0] pt_ra;
  assign pt_ra = (st_q == ST_MARK || st_q == ST_DIMS) ? idx_q[PtAw-1:0]
                                                      : PtAw'(idx_q + CntW'(1));
  logic rd_word_ok;
  assign rd_word_ok = (11'(job_q.read_row) < bh_q) && (32'(job_q.read_row) < GRID_ROWS) &&
                      (32'(job_q.read_word) < WordsPerRow) &&
                      ({job_q.read_word, 6'd0} < 10'(bw_q)  || bw_q[10]);
  assign read_addr = GwAw'(32'(job_q.read_row) * WordsPerRow + 32'(job_q.read_word));

  always_ff @(posedge clk_i) begin
    if (cur_add && job_i.op == OP_ADD && job_i.keep && !cur_full)
      pt_mem[total_q[PtAw-1:0]] <= {job_i.y, job_i.x};
    if (st_q == ST_DIMS && sub_q == 2'd0) pt_rd_q <= pt_mem[pt_ra];
    if (st_q == ST_MARK) pt_rd_q <= pt_mem[idx_q[PtAw-1:0]];
    if (st_q == ST_IDLE) job_q <= job_i;
    if (st_q == ST_WALK && dv_done && sub_q == 2'd1) cx_q <= dv_quo;
    if (st_q == ST_WALK && dv_done && sub_q == 2'd3) begin
      rd_ok_q <= in_map;
      cell_q  <= 64'd1 << cx_q[5:0];
      grid_rd_q <= grid_mem[mark_addr];
      mark_q    <= mark_addr;
    end
    if (st_q == ST_CLEAR) grid_mem[clr_q[GwAw-1:0]] <= 64'd0;
    if (st_q == ST_MARK && rd_ok_q)
      grid_mem[mark_q] <= grid_rd_q | cell_q;
    if (st_q == ST_READ) begin
      grid_rd_q <= grid_mem[read_addr];
      rd_ok_q   <= rd_word_ok;
    end
  end

  logic [63:0] word_mask;
  logic [10:0] rem_bits;
  assign rem_bits  = bw_q - {1'b0, job_q.read_word, 6'd0};
  assign word_mask = (rem_bits >= 11'd64) ? '1 : ((64'd1 << rem_bits[5:0]) - 64'd1);

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DONE) begin
      res_o.cell_bits <= (job_q.op == OP_READ && rd_ok_q) ? (grid_rd_q & word_mask) : 64'd0;
      res_o.grid_width     <= bw_q;
      res_o.grid_height    <= bh_q;
      res_o.origin_x       <= lox_q;
      res_o.origin_y       <= loy_q;
      res_o.kept_count     <= 13'(total_q);
      res_o.points_dropped <= drop_q;
      res_o.map_clipped    <= clip_q;
    end
  end

endmodule

### rtl/point_cloud_bev_occupancy_grid_core.sv
// Top level of the bird's-eye-view occupancy grid core.
//
// Channel   Direction  Handshake             Payload
// command   in         start, busy           cmd_i (cmd_t)
// result    out        done_o strobe         rsp_o (rsp_t)
// config    in         APB psel/penable      pwdata, prdata
//
// A point add or a new frame passes the front scaler's product and job registers, the job
// queue and the back part's idle and done states before the result strobe; a read also passes the read state.
// A build clears the grid one word a cycle, then spends two divisions on the map size
// and two divisions and one grid update on each stored point, all in one shared
// radix-2 divider. After reset the block is idle with an empty frame and an empty map.
// The receiver cannot stall, so results are never held back; busy follows only the front
// scaler and the job queue.
module point_cloud_bev_occupancy_grid_core import bev_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPoints,
  parameter int unsigned GRID_COLS  = GridCols,
  parameter int unsigned GRID_ROWS  = GridRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [23:0]        scale_q;
  logic signed [31:0] hlim_q;
  logic [30:0]        voxel_q;
  reg_e               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);

  // Registers take a write in the access phase of an APB transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 24'd65536;
      hlim_q  <= 32'sd0;
      voxel_q <= 31'd256;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_SCALE:  scale_q <= pwdata[23:0];
        REG_HLIMIT: hlim_q  <= pwdata;
        REG_VOXEL:  voxel_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCALE:  prdata = {8'd0, scale_q};
      REG_HLIMIT: prdata = hlim_q;
      REG_VOXEL:  prdata = {1'b0, voxel_q};
      default:    prdata = 32'd0;
    endcase
  end

  logic job_valid, q_ready, q_valid, q_pop;
  job_t job, q_job;

  bev_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (start),
    .cmd_i         (cmd_i),
    .scale_ratio_i (scale_q),
    .height_limit_i(hlim_q),
    .busy_o        (busy),
    .job_valid_o   (job_valid),
    .job_o         (job),
    .job_ready_i   (q_ready)
  );

  bev_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_valid & q_ready),
    .push_data_i(job),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .pop_data_o (q_job),
    .pop_i      (q_pop)
  );

  bev_back #(
    .MAX_POINTS(MAX_POINTS),
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .voxel_size_i(voxel_q),
    .res_valid_o (done_o),
    .res_o       (rsp_o)
  );

endmodule

### tb/sv/tb.sv
// Testbench for the bird's-eye-view occupancy grid core: directed commands and random frames checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
  import bev_pkg::*;

  // A build clears 16384 words and then takes two divisions and a grid update for each stored point.
  // The run holds about sixty builds of small frames. The limit below is several times
  // the cycles that these take.
  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned WordsPerRow = GridCols / 64;

  // The scoreboard keeps its own copy of the point store, the bounding box and the bit
  // grid. It works out the result for each accepted command when that command is
  // transferred. Results then come back in order, one for each command.
  class occupancy_scoreboard;
    logic [23:0]        scale;
    logic signed [31:0] hlimit;
    logic [30:0]        voxel;
    logic [63:0]        store[MaxPoints];
    int unsigned        total;
    longint             lo_x, hi_x, lo_y, hi_y;
    logic [63:0]        grid[GridRows * WordsPerRow];
    longint             bw, bh;
    logic               drop, clip;
    rsp_t               due[$];
    int                 errors;

    function new();
      scale  = 24'd65536;
      hlimit = 0;
      voxel  = 31'd256;
      foreach (grid[i]) grid[i] = '0;
      bw = 0;
      bh = 0;
      clip = 0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      total = 0;
      lo_x = 64'sd2147483647;
      lo_y = 64'sd2147483647;
      hi_x = -64'sd2147483648;
      hi_y = -64'sd2147483648;
      drop = 0;
    endfunction

    function void set_reg(reg_e r, logic [31:0] v);
      case (r)
        REG_SCALE:  scale = v[23:0];
        REG_HLIMIT: hlimit = v;
        default:    voxel = v[30:0];
      endcase
    endfunction

    // The product is floored to an integer (the scale is Q8.16) and then saturated to 32 bits.
    function longint scaled(logic signed [31:0] c);
      longint p, q;
      p = longint'(c) * longint'({40'd0, scale});
      q = p >>> 16;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function bit kept(logic signed [31:0] z);
      return scaled(z) > longint'(hlimit);
    endfunction

    function void build_map();
      longint v, cx, cy, x, y;
      v = (voxel == 0) ? 1 : longint'({33'd0, voxel});
      foreach (grid[i]) grid[i] = '0;
      clip = 0;
      bw = 0;
      bh = 0;
      if (total > 0) begin
        bw = (hi_x - lo_x) / v;
        bh = (hi_y - lo_y) / v;
      end
      if (bw > GridCols) begin
        bw = GridCols;
        clip = 1;
      end
      if (bh > GridRows) begin
        bh = GridRows;
        clip = 1;
      end
      for (int i = 0; i < total; i++) begin
        x = longint'($signed(store[i][31:0]));
        y = longint'($signed(store[i][63:32]));
        cx = (x - lo_x) / v;
        cy = (y - lo_y) / v;
        if (cx < bw && cy < bh)
          grid[(bh - 1 - cy) * WordsPerRow + (cx >> 6)][cx & 63] = 1'b1;
      end
    endfunction

    function void note(cmd_t c);
      rsp_t   e;
      longint x, y;
      e = '0;
      case (op_e'(c.op))
        OP_ADD: begin
          x = scaled(c.coord_x);
          y = scaled(c.coord_y);
          if (kept(c.coord_z)) begin
            if (total >= MaxPoints) begin
              drop = 1;
            end else begin
              store[total] = {y[31:0], x[31:0]};
              total++;
              if (x < lo_x) lo_x = x;
              if (x > hi_x) hi_x = x;
              if (y < lo_y) lo_y = y;
              if (y > hi_y) hi_y = y;
            end
          end
        end
        OP_BUILD: build_map();
        OP_READ: begin
          if (c.read_row < bh && longint'(c.read_word) * 64 < bw)
            e.cell_bits = grid[c.read_row * WordsPerRow + c.read_word];
        end
        default: clear_frame();
      endcase
      e.grid_width     = bw[10:0];
      e.grid_height    = bh[10:0];
      e.origin_x       = lo_x[31:0];
      e.origin_y       = lo_y[31:0];
      e.kept_count     = total[12:0];
      e.points_dropped = drop;
      e.map_clipped    = clip;
      due = {due, e};
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check(rsp_t r);
      rsp_t e;
      if (due.size() == 0) begin
        report("result with no command outstanding");
        return;
      end
      e = due.pop_front();
      if (r.cell_bits !== e.cell_bits)
        report($sformatf("cell_bits %h, expected %h", r.cell_bits, e.cell_bits));
      if (r.grid_width !== e.grid_width)
        report($sformatf("grid_width %0d, expected %0d", r.grid_width, e.grid_width));
      if (r.grid_height !== e.grid_height)
        report($sformatf("grid_height %0d, expected %0d", r.grid_height, e.grid_height));
      if (r.origin_x !== e.origin_x)
        report($sformatf("origin_x %h, expected %h", r.origin_x, e.origin_x));
      if (r.origin_y !== e.origin_y)
        report($sformatf("origin_y %h, expected %h", r.origin_y, e.origin_y));
      if (r.kept_count !== e.kept_count)
        report($sformatf("kept_count %0d, expected %0d", r.kept_count, e.kept_count));
      if (r.points_dropped !== e.points_dropped)
        report($sformatf("points_dropped %b, expected %b", r.points_dropped,
                         e.points_dropped));
      if (r.map_clipped !== e.map_clipped)
        report($sformatf("map_clipped %b, expected %b", r.map_clipped, e.map_clipped));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd_i;
  logic        done_o;
  rsp_t        rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  occupancy_scoreboard sb;
  int unsigned         cycles;
  bit                  quiet;
  // Per-frame placement of points: a base corner and how far points spread from it.
  int                  base_x, base_y;
  int unsigned         spread;

  point_cloud_bev_occupancy_grid_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results cannot be held off, so every strobe is one transfer into the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(rsp_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("point_cloud_bev_occupancy_grid_core verification failed");
      $finish;
    end
  end

  // Drives one command and returns at the edge that transfers it. The sender idles
  // now and then beforehand, unless the current stretch runs without gaps.
  task send(cmd_t c);
    if (!quiet && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    sb.note(c);
  endtask

  // Registers are written only when no result is outstanding and the block is idle.
  task write_reg(reg_e r, logic [31:0] v);
    start <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task configure(logic [23:0] s, logic signed [31:0] h, logic [30:0] v);
    write_reg(REG_SCALE, {8'd0, s});
    write_reg(REG_HLIMIT, h);
    write_reg(REG_VOXEL, {1'b0, v});
  endtask

  function cmd_t make_cmd(op_e op, int x, int y, int z, int row, int word);
    cmd_t c;
    c.op        = op;
    c.coord_x   = x;
    c.coord_y   = y;
    c.coord_z   = z;
    c.read_row  = row[9:0];
    c.read_word = word[3:0];
    return c;
  endfunction

  // Most points clear the height limit, so a z is redrawn a few times if needed.
  function cmd_t make_point();
    int z;
    z = $urandom();
    if ($urandom_range(0, 9) < 8) begin
      for (int t = 0; t < 8 && !sb.kept(z); t++) z = $urandom();
      if (!sb.kept(z)) z = 32'sh7fffffff;
    end
    return make_cmd(OP_ADD, base_x + int'($urandom_range(0, spread)),
                    base_y + int'($urandom_range(0, spread)), z, 0, 0);
  endfunction

  // Reads go mostly into the built map, and sometimes anywhere.
  function cmd_t make_read();
    int row, word;
    row = $urandom_range(0, 1023);
    word = $urandom_range(0, 15);
    if (sb.bh > 0 && $urandom_range(0, 3) != 0) begin
      row = $urandom_range(0, int'(sb.bh) - 1);
      word = $urandom_range(0, int'((sb.bw + 63) / 64));
    end
    return make_cmd(OP_READ, 0, 0, 0, row, word);
  endfunction

  function cmd_t make_noise();
    cmd_t c;
    c = make_cmd(op_e'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                 $urandom_range(0, 1023), $urandom_range(0, 15));
    return c;
  endfunction

  // One frame: new frame, a burst of points, a build, then reads of the map.
  // A few items of the frame are replaced by random commands.
  task run_frame(int unsigned npts);
    case ($urandom_range(0, 5))
      0:       spread = 0;
      1:       spread = 255;
      2:       spread = 300000;
      3:       spread = 32'h7fffffff;
      default: spread = $urandom_range(1000, 25000);
    endcase
    base_x = int'($urandom_range(0, 2000000)) - 1000000;
    base_y = int'($urandom_range(0, 2000000)) - 1000000;
    send(make_cmd(OP_FRAME, 0, 0, 0, 0, 0));
    for (int unsigned i = 0; i < npts; i++)
      send(($urandom_range(0, 9) == 0) ? make_noise() : make_point());
    send(make_cmd(OP_BUILD, 0, 0, 0, 0, 0));
    repeat ($urandom_range(1, 8))
      send(($urandom_range(0, 9) == 0) ? make_noise() : make_read());
  endtask

  initial begin
    sb      = new();
    cycles  = 0;
    quiet   = 1'b0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings: empty build, coordinate extremes, a point
    // right on the height limit, read address extremes and a new frame that keeps the map.
    send(make_cmd(OP_BUILD, 0, 0, 0, 0, 0));
    send(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    send(make_cmd(OP_ADD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0));
    send(make_cmd(OP_ADD, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 0));
    send(make_cmd(OP_ADD, 5, 7, 0, 0, 0));
    send(make_cmd(OP_ADD, 5, 7, 32'sh80000000, 0, 0));
    send(make_cmd(OP_BUILD, 0, 0, 0, 0, 0));
    send(make_cmd(OP_READ, 0, 0, 0, 1023, 15));
    send(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    send(make_cmd(OP_FRAME, 0, 0, 0, 0, 0));
    send(make_cmd(OP_ADD, 256, 512, 1, 0, 0));
    send(make_cmd(OP_ADD, 2560, 768, 1, 0, 0));
    send(make_cmd(OP_ADD, -1, -1, 1, 0, 0));
    send(make_cmd(OP_BUILD, 0, 0, 0, 0, 0));
    send(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    send(make_cmd(OP_READ, 0, 0, 0, 3, 0));
    send(make_cmd(OP_READ, 0, 0, 0, 1, 1));
    send(make_cmd(OP_FRAME, 0, 0, 0, 0, 0));
    send(make_cmd(OP_READ, 0, 0, 0, 2, 0));

    // Settings sweep: extremes of every register, a zero voxel size, and a limit that
    // nothing can clear. The third setting runs with no sender gaps at all.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: configure(24'hffffff, 32'sh80000000, 31'd1);
        1: configure(24'd0, -1, 31'd0);
        2: configure(24'd32768, 100, 31'd64);
        3: configure(24'd65536, 32'sh7fffffff, 31'h7fffffff);
        4: configure(24'($urandom()), int'($urandom_range(0, 20000)) - 10000,
                     31'($urandom_range(16, 4096)));
        5: configure(24'd131072, -5000, 31'd512);
        default: configure(24'd65536, 0, 31'd256);
      endcase
      quiet = (ph == 2);
      repeat (5) run_frame($urandom_range(1, 30));
    end
    quiet = 1'b0;

    // A larger frame at the reset settings, then reads and a new frame that keeps the map.
    spread = 20000;
    base_x = 1000;
    base_y = -1000;
    send(make_cmd(OP_FRAME, 0, 0, 0, 0, 0));
    for (int i = 0; i < 80; i++)
      send(make_cmd(OP_ADD, base_x + int'($urandom_range(0, spread)),
                    base_y + int'($urandom_range(0, spread)),
                    int'($urandom_range(1, 32'h7fffffff)), 0, 0));
    send(make_cmd(OP_BUILD, 0, 0, 0, 0, 0));
    repeat (6) send(make_read());
    send(make_cmd(OP_FRAME, 0, 0, 0, 0, 0));
    send(make_read());

    start <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("point_cloud_bev_occupancy_grid_core verification clean");
    end else begin
      $display("point_cloud_bev_occupancy_grid_core verification failed");
    end
    $finish;
  end

endmodule
